FILE: src/arp_pkg.sv
// shared types, constants and byte-select helpers for the arp request responder
// no dependencies
package arp_pkg;

   localparam logic [5:0] FRAME_LEN_POS = 6'd42;
   localparam logic [5:0] REPLY_LAST_POS = 6'd41;

   // received frame layout
   localparam logic [5:0] HDR_FIRST = 6'd12;
   localparam logic [5:0] HDR_LAST = 6'd21;
   localparam logic [5:0] SHA_FIRST = 6'd22;
   localparam logic [5:0] SHA_LAST = 6'd27;
   localparam logic [5:0] SPA_FIRST = 6'd28;
   localparam logic [5:0] SPA_LAST = 6'd31;
   localparam logic [5:0] TPA_FIRST = 6'd38;
   localparam logic [5:0] TPA_LAST = 6'd41;

   // reply frame layout
   localparam logic [5:0] RPL_DST = 6'd0;
   localparam logic [5:0] RPL_SRC = 6'd6;
   localparam logic [5:0] RPL_TYPE = 6'd12;
   localparam logic [5:0] RPL_HTYPE = 6'd14;
   localparam logic [5:0] RPL_PTYPE = 6'd16;
   localparam logic [5:0] RPL_HLEN = 6'd18;
   localparam logic [5:0] RPL_PLEN = 6'd19;
   localparam logic [5:0] RPL_OPER = 6'd20;
   localparam logic [5:0] RPL_SHA = 6'd22;
   localparam logic [5:0] RPL_SPA = 6'd28;
   localparam logic [5:0] RPL_THA = 6'd32;
   localparam logic [5:0] RPL_TPA = 6'd38;

   localparam logic [15:0] HW_TYPE_ETH = 16'h0001;
   localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [15:0] ETYPE_ARP = 16'h0806;
   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY = 16'h0002;
   localparam logic [7:0] MAC_ADDR_LEN = 8'd6;
   localparam logic [7:0] IP_ADDR_LEN = 8'd4;

   localparam int unsigned JOB_DEPTH = 2;
   localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // csr byte addresses
   localparam logic [3:0] ADDR_LOCAL_MAC = 4'h0;
   localparam logic [3:0] ADDR_LOCAL_IP = 4'h8;

   typedef struct packed {
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // byte k of a mac address, k = 0 is the first byte on the wire
   function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] k);
      logic [7:0] b;
      unique case (k)
         3'd0: b = v[47:40];
         3'd1: b = v[39:32];
         3'd2: b = v[31:24];
         3'd3: b = v[23:16];
         3'd4: b = v[15:8];
         default: b = v[7:0];
      endcase
      return b;
   endfunction

   function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0: b = v[31:24];
         2'd1: b = v[23:16];
         2'd2: b = v[15:8];
         default: b = v[7:0];
      endcase
      return b;
   endfunction

   // expected arp header bytes, idx 0 is frame position 12
   function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
      logic [7:0] b;
      unique case (idx)
         4'd0: b = ETYPE_ARP[15:8];
         4'd1: b = ETYPE_ARP[7:0];
         4'd2: b = HW_TYPE_ETH[15:8];
         4'd3: b = HW_TYPE_ETH[7:0];
         4'd4: b = ETYPE_IPV4[15:8];
         4'd5: b = ETYPE_IPV4[7:0];
         4'd6: b = MAC_ADDR_LEN;
         4'd7: b = IP_ADDR_LEN;
         4'd8: b = OPCODE_REQUEST[15:8];
         4'd9: b = OPCODE_REQUEST[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: src/arp_front.sv
// frame parser: checks the arp request header and target address, captures sender
// addresses and pushes one reply job per matching frame; uses arp_pkg
module arp_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 frame_byte,
   input  logic                       frame_last,
   input  logic [31:0]                local_ip,
   output logic                       job_push,
   output arp_pkg::job_type           job_data
);
   import arp_pkg::*;

   logic [5:0]  pos_ff, pos_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic        tgt_ok_ff, tgt_ok_in;
   logic [47:0] sha_ff, sha_in;
   logic [31:0] spa_ff, spa_in;

   always_comb begin
      pos_in = pos_ff;
      hdr_ok_in = hdr_ok_ff;
      tgt_ok_in = tgt_ok_ff;
      sha_in = sha_ff;
      spa_in = spa_ff;
      job_push = 1'b0;
      if (accept) begin
         if (pos_ff < FRAME_LEN_POS) begin
            pos_in = pos_ff + 6'd1;
            if (pos_ff >= HDR_FIRST && pos_ff <= HDR_LAST) begin
               if (frame_byte != hdr_byte(4'(pos_ff - HDR_FIRST))) hdr_ok_in = 1'b0;
            end else if (pos_ff >= SHA_FIRST && pos_ff <= SHA_LAST) begin
               sha_in = {sha_ff[39:0], frame_byte};
            end else if (pos_ff >= SPA_FIRST && pos_ff <= SPA_LAST) begin
               spa_in = {spa_ff[23:0], frame_byte};
            end else if (pos_ff >= TPA_FIRST && pos_ff <= TPA_LAST) begin
               if (frame_byte != ip_byte(local_ip, 2'(pos_ff - TPA_FIRST))) tgt_ok_in = 1'b0;
            end
         end
         if (frame_last) begin
            job_push = (pos_in == FRAME_LEN_POS) && hdr_ok_in && tgt_ok_in;
            pos_in = 6'd0;
            hdr_ok_in = 1'b1;
            tgt_ok_in = 1'b1;
         end
      end
   end

   assign job_data.sender_mac = sha_in;
   assign job_data.sender_ip = spa_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
         hdr_ok_ff <= 1'b1;
         tgt_ok_ff <= 1'b1;
         sha_ff <= 48'd0;
         spa_ff <= 32'd0;
      end else begin
         pos_ff <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
         tgt_ok_ff <= tgt_ok_in;
         sha_ff <= sha_in;
         spa_ff <= spa_in;
      end
   end

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= FRAME_LEN_POS)
      else $error("frame position beyond saturation");
   a_push_on_last: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (accept && frame_last && pos_ff >= REPLY_LAST_POS))
      else $error("reply job pushed without a complete frame");
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (accept && frame_last) |=> (pos_ff == 6'd0 && hdr_ok_ff && tgt_ok_ff))
      else $error("parser did not rearm after frame end");

endmodule

FILE: src/arp_queue.sv
// small job queue between the parser and the reply generator
// uses arp_pkg
module arp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  arp_pkg::job_type           push_data,
   input  logic                       pop,
   output arp_pkg::job_type           head,
   output arp_pkg::queue_status_type  status
);
   import arp_pkg::*;

   job_type               mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]  cnt_ff, cnt_in;

   localparam logic [JOB_PTR_W-1:0] PTR_END = JOB_PTR_W'(JOB_DEPTH - 1);
   localparam logic [JOB_CNT_W-1:0] CNT_FULL = JOB_CNT_W'(JOB_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_END) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_END) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign status.full = (cnt_ff == CNT_FULL);
   assign status.empty = (cnt_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("job queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("job queue underflow");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL)
      else $error("job count out of range");

endmodule

FILE: src/arp_back.sv
// reply generator: walks a 42-byte arp reply for each queued job into an output register
// uses arp_pkg
module arp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  arp_pkg::job_type           job,
   input  logic                       job_valid,
   output logic                       job_pop,
   input  logic [47:0]                local_mac,
   input  logic [31:0]                local_ip,
   input  logic                       pop,
   output logic                       empty,
   output logic [7:0]                 reply_byte,
   output logic                       reply_last
);
   import arp_pkg::*;

   logic [5:0] cnt_ff, cnt_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic [7:0] next_byte;
   logic       load;

   always_comb begin
      unique case (cnt_ff) inside
         [RPL_DST:RPL_SRC - 6'd1]:  next_byte = mac_byte(job.sender_mac, 3'(cnt_ff - RPL_DST));
         [RPL_SRC:RPL_TYPE - 6'd1]: next_byte = mac_byte(local_mac, 3'(cnt_ff - RPL_SRC));
         RPL_TYPE:                  next_byte = ETYPE_ARP[15:8];
         RPL_TYPE + 6'd1:           next_byte = ETYPE_ARP[7:0];
         RPL_HTYPE:                 next_byte = HW_TYPE_ETH[15:8];
         RPL_HTYPE + 6'd1:          next_byte = HW_TYPE_ETH[7:0];
         RPL_PTYPE:                 next_byte = ETYPE_IPV4[15:8];
         RPL_PTYPE + 6'd1:          next_byte = ETYPE_IPV4[7:0];
         RPL_HLEN:                  next_byte = MAC_ADDR_LEN;
         RPL_PLEN:                  next_byte = IP_ADDR_LEN;
         RPL_OPER:                  next_byte = OPCODE_REPLY[15:8];
         RPL_OPER + 6'd1:           next_byte = OPCODE_REPLY[7:0];
         [RPL_SHA:RPL_SPA - 6'd1]:  next_byte = mac_byte(local_mac, 3'(cnt_ff - RPL_SHA));
         [RPL_SPA:RPL_THA - 6'd1]:  next_byte = ip_byte(local_ip, 2'(cnt_ff - RPL_SPA));
         [RPL_THA:RPL_TPA - 6'd1]:  next_byte = mac_byte(job.sender_mac, 3'(cnt_ff - RPL_THA));
         [RPL_TPA:REPLY_LAST_POS]:  next_byte = ip_byte(job.sender_ip, 2'(cnt_ff - RPL_TPA));
         default:                   next_byte = 8'h00;
      endcase
   end

   always_comb begin
      load = job_valid && (!out_valid_ff || pop);
      cnt_in = cnt_ff;
      out_valid_in = out_valid_ff && !pop;
      job_pop = 1'b0;
      if (load) begin
         out_valid_in = 1'b1;
         if (cnt_ff == REPLY_LAST_POS) begin
            cnt_in = 6'd0;
            job_pop = 1'b1;
         end else begin
            cnt_in = cnt_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 6'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= next_byte;
         last_ff <= (cnt_ff == REPLY_LAST_POS);
      end
   end

   assign empty = !out_valid_ff;
   assign reply_byte = byte_ff;
   assign reply_last = last_ff;

   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> (cnt_ff == 6'd0))
      else $error("reply counter moved without a job");
   a_pop_at_end: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (load && cnt_ff == REPLY_LAST_POS))
      else $error("job released before its reply was complete");
   a_last_marks_end: assert property (@(posedge clock) disable iff (reset)
      load |=> (reply_last == $past(job_pop)))
      else $error("last marker not on final reply byte");

endmodule

FILE: src/arp_request_responder_top.sv
// top level of the arp request responder: csr registers and the parser, queue, generator
// depends on arp_pkg, arp_front, arp_queue, arp_back
//
// usage
//   request side: received ethernet frame, one byte per word on req_frame_byte, with
//   req_frame_last on the final byte; a word is taken when push is high and full low
//   reply side: the 42-byte arp reply, one byte per word on rsp_reply_byte with
//   rsp_reply_last on the final byte; a word is taken when pop is high and empty low
//   csr: local_mac at byte address 0x0, local_ip at 0x8, 64-bit data, no wait states
// timing
//   the parser takes one byte per cycle while full is low; a matching frame's job is
//   queued, then its reply bytes are registered one per cycle while pop is held
//   the draining reply keeps its job entry, so one more frame can finish parsing;
//   full rises only while that queue is full
// reset
//   clears the parser, empties the job queue and output register, zeroes both csrs
// stall
//   holding pop low freezes the output word; the parser keeps running until the
//   job queue fills
module arp_request_responder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_last,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_reply_byte,
   output logic        rsp_reply_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready
);
   import arp_pkg::*;

   logic [47:0]      mac_ff, mac_in;
   logic [31:0]      ip_ff, ip_in;
   logic             csr_write;
   logic             accept;
   logic             job_push;
   logic             job_pop;
   job_type          push_data;
   job_type          head;
   queue_status_type q_status;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      mac_in = mac_ff;
      ip_in = ip_ff;
      if (csr_write) begin
         if (paddr[3] == ADDR_LOCAL_IP[3]) ip_in = pwdata[31:0];
         else mac_in = pwdata[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= 48'd0;
         ip_ff <= 32'd0;
      end else begin
         mac_ff <= mac_in;
         ip_ff <= ip_in;
      end
   end

   assign prdata = (paddr[3] == ADDR_LOCAL_MAC[3]) ? {16'd0, mac_ff} : {32'd0, ip_ff};

   assign full = q_status.full;
   assign accept = push && !full;

   arp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_frame_byte),
      .frame_last (req_frame_last),
      .local_ip   (ip_ff),
      .job_push   (job_push),
      .job_data   (push_data)
   );

   arp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .head      (head),
      .status    (q_status)
   );

   arp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (head),
      .job_valid  (!q_status.empty),
      .job_pop    (job_pop),
      .local_mac  (mac_ff),
      .local_ip   (ip_ff),
      .pop        (pop),
      .empty      (empty),
      .reply_byte (rsp_reply_byte),
      .reply_last (rsp_reply_last)
   );

endmodule
